// ===== hw/rtl/rcwc_pkg.sv =====
// Shared types, codes and constants of the Reno congestion window controller.
`default_nettype none

package rcwc_pkg;

	// Field widths
	localparam int unsigned KIND_W      = 2;
	localparam int unsigned ACK_IN_W    = 8;
	localparam int unsigned ACK_W       = 9;
	localparam int unsigned MSS_W       = 16;
	localparam int unsigned LIMIT_W     = 8;
	localparam int unsigned WIN_W       = 32;
	localparam int unsigned SEQ_OUT_W   = 8;
	localparam int unsigned DUP_W       = 8;
	localparam int unsigned PROD_W      = 32;
	localparam int unsigned DIVIDEND_W  = 48;
	localparam int unsigned DIV_CNT_W   = $clog2(DIVIDEND_W);
	localparam int unsigned CAP_PROD_W  = LIMIT_W + MSS_W;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned SEQ_SPACE_DEFAULT = 256;

	// Event kinds on the request port
	localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEND   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_THRESHOLD = 2'd2;

	// Reset values
	localparam logic [MSS_W-1:0]   SEG_SIZE_RESET  = 16'd1024;
	localparam logic [LIMIT_W-1:0] WIN_LIMIT_RESET = 8'd8;
	localparam logic [LIMIT_W-1:0] INIT_THR_RESET  = 8'd6;
	localparam logic [WIN_W-1:0]   CWND_RESET      = WIN_W'(SEG_SIZE_RESET);
	localparam logic [WIN_W-1:0]   THR_RESET       = WIN_W'(INIT_THR_RESET * SEG_SIZE_RESET);
	localparam logic [WIN_W-1:0]   CAP_RESET       = WIN_W'(WIN_LIMIT_RESET * SEG_SIZE_RESET);

	localparam logic [WIN_W-1:0] WIN_MAX       = {WIN_W{1'b1}};
	localparam logic [DUP_W-1:0] DUP_MAX       = {DUP_W{1'b1}};
	localparam logic [DUP_W-1:0] DUP_ACK_LIMIT = 8'd3;

	typedef enum logic [1:0] {
		OP_ACK,
		OP_SEND,
		OP_EXPIRE,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		PH_SLOW_START = 2'd0,
		PH_AVOID      = 2'd1,
		PH_RECOVERY   = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		BK_LOAD,
		BK_CLASSIFY,
		BK_ACK_MUL,
		BK_ACK_NEW,
		BK_DIV_GO,
		BK_DIV_WAIT,
		BK_WRITE
	} back_state_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [ACK_IN_W-1:0] ack_number;
	} in_item_t;

	typedef struct packed {
		logic [WIN_W-1:0]     send_window;
		logic [WIN_W-1:0]     congestion_window;
		logic [WIN_W-1:0]     slow_start_threshold;
		logic [1:0]           stage;
		logic                 fast_retransmit;
		logic                 resend_all;
		logic                 timer_running;
		logic [SEQ_OUT_W-1:0] window_base;
		logic [SEQ_OUT_W-1:0] newly_acked;
	} out_item_t;

	// Decoded event: operation and the new window base an ACK would give
	typedef struct packed {
		op_t              op;
		logic [ACK_W-1:0] ack_next;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcwc_fifo.sv =====
// Two-entry register queue used between the controller's parts.
`default_nettype none

module rcwc_fifo #(
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output item_t rdata,
	output logic  empty
);
	import rcwc_pkg::*;

	localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

	item_t           mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CntFull);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	// Store an incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rcwc_front.sv =====
// Front end: decodes an event beat into an operation and a reduced ACK number.
`default_nettype none

module rcwc_front #(
	parameter int unsigned SEQ_SPACE = rcwc_pkg::SEQ_SPACE_DEFAULT
) (
	input  rcwc_pkg::in_item_t request,
	output rcwc_pkg::cmd_t     cmd
);
	import rcwc_pkg::*;

	localparam int unsigned AckRange = 2 ** ACK_IN_W;

	// ACK number reduced into the sequence space, plus one, wrapped
	logic [ACK_W-1:0] next_tbl [AckRange];

	for (genvar i = 0; i < AckRange; i++) begin : g_next_tbl
		assign next_tbl[i] = ACK_W'(((i % SEQ_SPACE) + 1) % SEQ_SPACE);
	end

	// Classify the event kind and look up the next window base
	always_comb begin
		cmd.ack_next = next_tbl[request.ack_number];
		unique case (request.kind)
			KIND_ACK:    cmd.op = OP_ACK;
			KIND_SEND:   cmd.op = OP_SEND;
			KIND_EXPIRE: cmd.op = OP_EXPIRE;
			default:     cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rcwc_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the avoidance increment.
`default_nettype none

module rcwc_divider (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [rcwc_pkg::DIVIDEND_W-1:0]      dividend,
	input  logic [rcwc_pkg::WIN_W-1:0]           divisor,
	output logic                                 done,
	output logic [rcwc_pkg::DIVIDEND_W-1:0]      quotient
);
	import rcwc_pkg::*;

	localparam logic [DIV_CNT_W-1:0] LastStep = DIV_CNT_W'(DIVIDEND_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [WIN_W-1:0]      rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [WIN_W-1:0]      dsr_q;
	logic [WIN_W:0]        shifted;
	logic                  ge;
	logic [WIN_W-1:0]      rem_next;

	// Shift in the next dividend bit and try a subtract
	assign shifted  = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge       = (shifted >= {1'b0, dsr_q});
	assign rem_next = ge ? WIN_W'(shifted - {1'b0, dsr_q}) : shifted[WIN_W-1:0];

	assign done     = done_q;
	assign quotient = quo_q;

	// Count steps, flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == LastStep) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load operands, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rcwc_back.sv =====
// Back end: holds the Reno state and carries out one decoded event at a time.
`default_nettype none

module rcwc_back #(
	parameter int unsigned SEQ_SPACE = rcwc_pkg::SEQ_SPACE_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcwc_pkg::cmd_t                cmd,
	input  logic                          cmd_empty,
	output logic                          cmd_pop,
	input  logic [rcwc_pkg::MSS_W-1:0]    seg_size,
	input  logic [rcwc_pkg::WIN_W-1:0]    win_cap,
	input  logic                          res_full,
	output logic                          res_push,
	output rcwc_pkg::out_item_t           res
);
	import rcwc_pkg::*;

	localparam int unsigned     SeqW      = $clog2(SEQ_SPACE);
	localparam logic [SeqW:0]   SpaceWide = (SeqW + 1)'(SEQ_SPACE);
	localparam logic [SeqW-1:0] SpaceMod  = SeqW'(SEQ_SPACE);
	localparam logic [SeqW:0]   SendLimit = (SeqW + 1)'(SEQ_SPACE - 1);

	back_state_t state_q;
	back_state_t state_d;

	// Reno state
	phase_t           phase_q;
	logic [WIN_W-1:0] cwnd_q;
	logic [WIN_W-1:0] thr_q;
	logic [DUP_W-1:0] dup_q;
	logic [SeqW-1:0]  base_q;
	logic [SeqW-1:0]  next_q;
	logic             timer_q;
	logic             fast_q;
	logic             resend_q;
	logic [SeqW-1:0]  acked_q;

	// Per-event working registers
	op_t               op_q;
	logic [SeqW-1:0]   ack_q;
	logic [SeqW-1:0]   d_q;
	logic              new_q;
	logic [PROD_W-1:0] prod_q;
	logic [DIVIDEND_W-1:0] prod2_q;

	logic [SeqW:0]     d_raw;
	logic [SeqW:0]     outst_raw;
	logic [SeqW-1:0]   d_w;
	logic [SeqW-1:0]   outst_w;
	logic [SeqW:0]     next_inc;
	logic [SeqW-1:0]   next_wrap;
	logic [SeqW+MSS_W-1:0] prod_w;
	logic [DIVIDEND_W-1:0] prod2_w;
	logic [WIN_W:0]    ss_sum;
	logic [WIN_W-1:0]  ss_cwnd;
	logic [WIN_W:0]    rec_sum;
	logic [WIN_W-1:0]  rec_cwnd;
	logic [MSS_W+1:0]  three_mss;
	logic [WIN_W:0]    fr_sum;
	logic [WIN_W-1:0]  fr_thr;
	logic [DUP_W-1:0]  dup_next;
	logic [WIN_W-1:0]  div_divisor;
	logic              div_start;
	logic              div_done;
	logic [DIVIDEND_W-1:0] div_quo;
	logic [DIVIDEND_W:0]   ca_sum;
	logic [WIN_W-1:0]  ca_cwnd;

	// Sequence distances modulo the sequence space
	assign d_raw     = {1'b0, ack_q} - {1'b0, base_q};
	assign d_w       = d_raw[SeqW] ? d_raw[SeqW-1:0] + SpaceMod : d_raw[SeqW-1:0];
	assign outst_raw = {1'b0, next_q} - {1'b0, base_q};
	assign outst_w   = outst_raw[SeqW] ? outst_raw[SeqW-1:0] + SpaceMod : outst_raw[SeqW-1:0];
	assign next_inc  = {1'b0, next_q} + (SeqW + 1)'(1);
	assign next_wrap = (next_inc == SpaceWide) ? '0 : next_inc[SeqW-1:0];

	// Window growth terms; the sums saturate at the top of the range
	assign prod_w    = d_q * seg_size;
	assign prod2_w   = prod_q * seg_size;
	assign ss_sum    = {1'b0, cwnd_q} + {1'b0, prod_q};
	assign ss_cwnd   = ss_sum[WIN_W] ? WIN_MAX : ss_sum[WIN_W-1:0];
	assign rec_sum   = {1'b0, cwnd_q} + (WIN_W + 1)'(seg_size);
	assign rec_cwnd  = rec_sum[WIN_W] ? WIN_MAX : rec_sum[WIN_W-1:0];
	assign three_mss = {1'b0, seg_size, 1'b0} + (MSS_W + 2)'(seg_size);
	assign fr_sum    = (WIN_W + 1)'(cwnd_q[WIN_W-1:1]) + (WIN_W + 1)'(three_mss);
	assign fr_thr    = fr_sum[WIN_W] ? WIN_MAX : fr_sum[WIN_W-1:0];
	assign dup_next  = (dup_q == DUP_MAX) ? dup_q : dup_q + DUP_W'(1);

	// Avoidance increment: d*MSS*MSS / cwnd, zero cwnd divides by one
	assign div_divisor = (cwnd_q == '0) ? WIN_W'(1) : cwnd_q;
	assign ca_sum      = (DIVIDEND_W + 1)'(cwnd_q) + (DIVIDEND_W + 1)'(div_quo);
	assign ca_cwnd     = (|ca_sum[DIVIDEND_W:WIN_W]) ? WIN_MAX : ca_sum[WIN_W-1:0];

	rcwc_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod2_q),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_LOAD:     if (!cmd_empty) state_d = BK_CLASSIFY;
			BK_CLASSIFY: state_d = (op_q == OP_ACK) ? BK_ACK_MUL : BK_WRITE;
			BK_ACK_MUL:  state_d = new_q ? BK_ACK_NEW : BK_WRITE;
			BK_ACK_NEW:  state_d = (phase_q == PH_AVOID) ? BK_DIV_GO : BK_WRITE;
			BK_DIV_GO:   state_d = BK_DIV_WAIT;
			BK_DIV_WAIT: if (div_done) state_d = BK_WRITE;
			BK_WRITE:    if (!res_full) state_d = BK_LOAD;
			default:     state_d = BK_LOAD;
		endcase
	end

	// Handshake outputs
	always_comb begin
		cmd_pop   = (state_q == BK_LOAD) && !cmd_empty;
		div_start = (state_q == BK_DIV_GO);
		res_push  = (state_q == BK_WRITE) && !res_full;
	end

	// Result beat from the state after the event
	always_comb begin
		res.send_window          = (cwnd_q < win_cap) ? cwnd_q : win_cap;
		res.congestion_window    = cwnd_q;
		res.slow_start_threshold = thr_q;
		res.stage                = phase_q;
		res.fast_retransmit      = fast_q;
		res.resend_all           = resend_q;
		res.timer_running        = timer_q;
		res.window_base          = SEQ_OUT_W'(base_q);
		res.newly_acked          = SEQ_OUT_W'(acked_q);
	end

	// Update the Reno state step by step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_LOAD;
			phase_q  <= PH_SLOW_START;
			cwnd_q   <= CWND_RESET;
			thr_q    <= THR_RESET;
			dup_q    <= '0;
			base_q   <= '0;
			next_q   <= '0;
			timer_q  <= 1'b0;
			fast_q   <= 1'b0;
			resend_q <= 1'b0;
			acked_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				BK_LOAD: begin
					if (cmd_pop) begin
						fast_q   <= 1'b0;
						resend_q <= 1'b0;
						acked_q  <= '0;
					end
				end
				BK_CLASSIFY: begin
					unique case (op_q)
						OP_SEND: begin
							// drop a send once the sequence space is full
							if ({1'b0, outst_w} < SendLimit) begin
								next_q  <= next_wrap;
								timer_q <= 1'b1;
							end
						end
						OP_EXPIRE: begin
							// an idle timer expiry does nothing
							if (timer_q) begin
								resend_q <= 1'b1;
								thr_q    <= {1'b0, cwnd_q[WIN_W-1:1]};
								cwnd_q   <= WIN_W'(seg_size);
								dup_q    <= '0;
								phase_q  <= PH_SLOW_START;
								timer_q  <= (base_q != next_q);
							end
						end
						OP_ACK:  ;
						OP_NONE: ;
					endcase
				end
				BK_ACK_MUL: begin
					// duplicate ACK: count, enter recovery on the third, inflate in recovery
					if (!new_q) begin
						dup_q   <= dup_next;
						timer_q <= (base_q != next_q);
						if (phase_q != PH_RECOVERY) begin
							if (dup_next == DUP_ACK_LIMIT) begin
								thr_q   <= fr_thr;
								cwnd_q  <= fr_thr;
								phase_q <= PH_RECOVERY;
								fast_q  <= 1'b1;
							end
						end else begin
							cwnd_q <= rec_cwnd;
						end
					end
				end
				BK_ACK_NEW: begin
					unique case (phase_q)
						PH_SLOW_START: begin
							cwnd_q <= ss_cwnd;
							if (ss_cwnd >= thr_q) begin
								phase_q <= PH_AVOID;
							end
						end
						PH_RECOVERY: begin
							cwnd_q  <= thr_q;
							phase_q <= PH_AVOID;
						end
						default: ;
					endcase
					dup_q   <= '0;
					base_q  <= ack_q;
					acked_q <= d_q;
					timer_q <= (ack_q != next_q);
				end
				BK_DIV_WAIT: begin
					if (div_done) begin
						cwnd_q <= ca_cwnd;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the event in flight
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			op_q  <= cmd.op;
			ack_q <= SeqW'(cmd.ack_next);
		end
		if (state_q == BK_CLASSIFY) begin
			d_q   <= d_w;
			new_q <= (d_w != '0) && (d_w <= outst_w);
		end
		if (state_q == BK_ACK_MUL) begin
			prod_q <= PROD_W'(prod_w);
		end
		if (state_q == BK_ACK_NEW) begin
			prod2_q <= prod2_w;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/reno_congestion_window_control.sv =====
// Top level of the Reno congestion window controller.
`default_nettype none

// Sender-side Reno congestion controller. Each event beat (ACK, segment sent,
// timer expiry) yields exactly one result beat carrying the send window,
// cwnd, ssthresh, stage, request flags, timer state, window base and newly
// acked count. Events are decoded into a two-entry command queue and executed
// one at a time by a sequencer; results wait in a two-entry queue, so push
// and pop stall independently. A send, expiry or unknown event passes through
// load, classify and write; an ACK also passes the multiply state, and a new
// ACK then the update state and, in congestion avoidance, the 48-step restoring
// divider that forms d*MSS*MSS/cwnd. Configuration writes are always ready and
// must only be issued while the block is idle; writes to the initial threshold
// index are ignored, and ssthresh resets from INIT_THR_RESET.
module reno_congestion_window_control #(
	parameter int unsigned SEQ_SPACE = rcwc_pkg::SEQ_SPACE_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  rcwc_pkg::in_item_t                request,
	output logic                              empty,
	input  logic                              pop,
	output rcwc_pkg::out_item_t               result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcwc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcwc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rcwc_pkg::*;

	logic [MSS_W-1:0]      seg_size_q;
	logic [LIMIT_W-1:0]    win_limit_q;
	logic [WIN_W-1:0]      cap_q;
	logic [CAP_PROD_W-1:0] cap_prod;

	cmd_t      cmd_in;
	cmd_t      cmd_head;
	logic      cmd_empty;
	logic      cmd_pop;
	out_item_t res_beat;
	logic      res_full;
	logic      res_push;

	assign cfg_ready = 1'b1;
	assign cap_prod  = win_limit_q * seg_size_q;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_size_q  <= SEG_SIZE_RESET;
			win_limit_q <= WIN_LIMIT_RESET;
			cap_q       <= CAP_RESET;
		end else begin
			cap_q <= WIN_W'(cap_prod);
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_SEGMENT_SIZE: seg_size_q  <= cfg_data;
					CFG_WINDOW_LIMIT: win_limit_q <= cfg_data[LIMIT_W-1:0];
					// held thresholds are never rewritten by configuration
					CFG_INIT_THRESHOLD: ;
					default: ;
				endcase
			end
		end
	end

	rcwc_front #(
		.SEQ_SPACE (SEQ_SPACE)
	) u_front (
		.request (request),
		.cmd     (cmd_in)
	);

	rcwc_fifo #(
		.item_t (cmd_t)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	rcwc_back #(
		.SEQ_SPACE (SEQ_SPACE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.seg_size  (seg_size_q),
		.win_cap   (cap_q),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_beat)
	);

	rcwc_fifo #(
		.item_t (out_item_t)
	) u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_beat),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

`default_nettype wire

// ===== tb/sv/reno_congestion_window_control_test.sv =====
// Self-checking testbench for the Reno congestion window controller.
`default_nettype none

module reno_congestion_window_control_test;
	import rcwc_pkg::*;

	localparam int unsigned SEQ_SPACE      = 256;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned TAIL_CYCLES    = 80;

	typedef struct {
		in_item_t  ev;
		logic      typed;
		out_item_t want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	in_item_t              request   = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	out_item_t             result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Predicted controller state and register copies
	phase_t      cc_stage;
	logic [31:0] cc_cwnd;
	logic [31:0] cc_thresh;
	logic [7:0]  cc_dups;
	int unsigned cc_base;
	int unsigned cc_next;
	logic        cc_timer;
	logic [15:0] cfg_mss;
	logic [7:0]  cfg_wlim;
	logic [7:0]  cfg_ithr;

	out_item_t   window_reports_due[$];
	int unsigned mismatch_count = 0;
	int unsigned events_sent    = 0;
	int unsigned burst_left     = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned rcv_mode       = 0;
	int unsigned rcv_left       = 0;
	bit          tail_flush     = 1'b0;

	reno_congestion_window_control #(
		.SEQ_SPACE(SEQ_SPACE)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] clamp32(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	// Apply one event to the predicted state and form its result beat
	function automatic out_item_t reno_advance(input in_item_t ev);
		out_item_t   rep;
		int unsigned ack;
		int unsigned span;
		int unsigned in_flight;
		logic [63:0] mss;
		logic [63:0] divisor;
		logic [31:0] cap;
		rep = '0;
		mss = 64'(cfg_mss);
		in_flight = (cc_next + SEQ_SPACE - cc_base) % SEQ_SPACE;
		case (op_t'(ev.kind))
			OP_ACK: begin
				ack = ev.ack_number;
				ack = ack % SEQ_SPACE;
				span = ((ack + 1) % SEQ_SPACE + SEQ_SPACE - cc_base) % SEQ_SPACE;
				if (span >= 1 && span <= in_flight) begin
					// New ACK: grow by stage, slide the base
					case (cc_stage)
						PH_SLOW_START: begin
							cc_cwnd = clamp32(64'(cc_cwnd) + 64'(span) * mss);
							if (cc_cwnd >= cc_thresh)
								cc_stage = PH_AVOID;
						end
						PH_AVOID: begin
							divisor = (cc_cwnd == 32'd0) ? 64'd1 : 64'(cc_cwnd);
							cc_cwnd = clamp32(64'(cc_cwnd) + 64'(span) * mss * mss / divisor);
						end
						default: begin
							cc_cwnd  = cc_thresh;
							cc_stage = PH_AVOID;
						end
					endcase
					cc_dups = '0;
					cc_base = (ack + 1) % SEQ_SPACE;
					rep.newly_acked = 8'(span);
				end else begin
					// Duplicate: count, enter recovery on the third, inflate inside it
					if (cc_dups != DUP_MAX)
						cc_dups++;
					if (cc_stage != PH_RECOVERY) begin
						if (cc_dups == DUP_ACK_LIMIT) begin
							cc_thresh = clamp32(64'(cc_cwnd / 2) + 3 * mss);
							cc_cwnd   = cc_thresh;
							cc_stage  = PH_RECOVERY;
							rep.fast_retransmit = 1'b1;
						end
					end else begin
						cc_cwnd = clamp32(64'(cc_cwnd) + mss);
					end
				end
				cc_timer = (cc_base != cc_next);
			end
			OP_SEND: begin
				if (in_flight < SEQ_SPACE - 1) begin
					cc_next  = (cc_next + 1) % SEQ_SPACE;
					cc_timer = 1'b1;
				end
			end
			OP_EXPIRE: begin
				if (cc_timer) begin
					rep.resend_all = 1'b1;
					cc_thresh = cc_cwnd / 2;
					cc_cwnd   = 32'(cfg_mss);
					cc_dups   = '0;
					cc_stage  = PH_SLOW_START;
					cc_timer  = (cc_base != cc_next);
				end
			end
			default: ;
		endcase
		cap = 32'(cfg_wlim) * 32'(cfg_mss);
		rep.send_window          = (cc_cwnd < cap) ? cc_cwnd : cap;
		rep.congestion_window    = cc_cwnd;
		rep.slow_start_threshold = cc_thresh;
		rep.stage                = cc_stage;
		rep.timer_running        = cc_timer;
		rep.window_base          = 8'(cc_base);
		return rep;
	endfunction

	function automatic out_item_t snapshot(input logic [31:0] win, input logic [31:0] cwnd,
			input logic [31:0] thr, input phase_t st, input logic fast, input logic resend,
			input logic tmr, input logic [7:0] base, input logic [7:0] acked);
		out_item_t rep;
		rep.send_window          = win;
		rep.congestion_window    = cwnd;
		rep.slow_start_threshold = thr;
		rep.stage                = st;
		rep.fast_retransmit      = fast;
		rep.resend_all           = resend;
		rep.timer_running        = tmr;
		rep.window_base          = base;
		rep.newly_acked          = acked;
		return rep;
	endfunction

	function automatic dir_row_t row_free(input op_t k, input logic [7:0] ack);
		dir_row_t r;
		r.ev.kind       = k;
		r.ev.ack_number = ack;
		r.typed         = 1'b0;
		r.want          = '0;
		return r;
	endfunction

	function automatic dir_row_t row_fixed(input op_t k, input logic [7:0] ack,
			input out_item_t want);
		dir_row_t r;
		r = row_free(k, ack);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Drive one event beat, hold it until taken, then log its expected result
	task automatic post_event(input in_item_t ev, input logic typed, input out_item_t want);
		out_item_t guess;
		push    <= 1'b1;
		request <= ev;
		do @(posedge clk); while (full);
		guess = reno_advance(ev);
		window_reports_due.push_back(typed ? want : guess);
		events_sent++;
	endtask

	task automatic hold_off(input int unsigned cycles);
		push <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending until every expected beat has come back
	task automatic settle();
		push <= 1'b0;
		while (window_reports_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Send in bursts with random gaps between them
	task automatic offer(input op_t k, input logic [7:0] ack);
		in_item_t    ev;
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0)
				hold_off(gap);
		end
		burst_left--;
		ev.kind       = k;
		ev.ack_number = ack;
		post_event(ev, 1'b0, '0);
	endtask

	// Write all three registers; the block must be idle
	task automatic program_regs(input logic [15:0] mss, input logic [7:0] wlim,
			input logic [7:0] ithr);
		logic [CFG_IDX_W-1:0]  idx[3];
		logic [CFG_DATA_W-1:0] val[3];
		idx = '{CFG_SEGMENT_SIZE, CFG_WINDOW_LIMIT, CFG_INIT_THRESHOLD};
		val = '{mss, {8'h00, wlim}, {8'h00, ithr}};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				CFG_SEGMENT_SIZE: cfg_mss  = val[i];
				CFG_WINDOW_LIMIT: cfg_wlim = val[i][7:0];
				default:          cfg_ithr = val[i][7:0];
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Mostly send-then-ACK rounds, with duplicates, expiries, noise and drains
	task automatic run_traffic(input int unsigned quota);
		int unsigned start;
		int unsigned in_flight;
		int unsigned pick;
		int unsigned span;
		start = events_sent;
		while (events_sent - start < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				offer(op_t'($urandom_range(0, 3)), 8'($urandom));
			end else if (pick < 11) begin
				offer(OP_EXPIRE, 8'($urandom));
			end else if (pick < 15) begin
				repeat ($urandom_range(1, 5))
					offer(OP_ACK, 8'((cc_base + SEQ_SPACE - 1) % SEQ_SPACE));
			end else if (pick < 16) begin
				settle();
			end else begin
				repeat ($urandom_range(1, 8))
					offer(OP_SEND, 8'($urandom));
				repeat ($urandom_range(1, 2)) begin
					in_flight = (cc_next + SEQ_SPACE - cc_base) % SEQ_SPACE;
					if (in_flight != 0) begin
						span = $urandom_range(1, in_flight);
						offer(OP_ACK, 8'((cc_base + span - 1) % SEQ_SPACE));
					end
				end
			end
		end
	endtask

	// Fill the sequence space past its limit, then ACK everything at once
	task automatic flood_window();
		int unsigned in_flight;
		repeat (SEQ_SPACE + 2)
			offer(OP_SEND, 8'($urandom));
		in_flight = (cc_next + SEQ_SPACE - cc_base) % SEQ_SPACE;
		offer(OP_ACK, 8'((cc_base + in_flight - 1) % SEQ_SPACE));
	endtask

	// Result side: check each beat, then pop on a stall pattern of its own
	always @(posedge clk) begin : result_side
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (window_reports_due.size() == 0) begin
				$error("result beat with no event pending");
				mismatch_count++;
			end else begin
				want = window_reports_due.pop_front();
				check_field("send_window", want.send_window, result.send_window);
				check_field("congestion_window", want.congestion_window,
					result.congestion_window);
				check_field("slow_start_threshold", want.slow_start_threshold,
					result.slow_start_threshold);
				check_field("stage", 32'(want.stage), 32'(result.stage));
				check_field("fast_retransmit", 32'(want.fast_retransmit),
					32'(result.fast_retransmit));
				check_field("resend_all", 32'(want.resend_all), 32'(result.resend_all));
				check_field("timer_running", 32'(want.timer_running),
					32'(result.timer_running));
				check_field("window_base", 32'(want.window_base), 32'(result.window_base));
				check_field("newly_acked", 32'(want.newly_acked), 32'(result.newly_acked));
			end
		end
		if (rcv_left == 0) begin
			rcv_mode = $urandom_range(0, 3);
			rcv_left = $urandom_range(10, 150);
		end
		rcv_left--;
		if (tail_flush)
			pop <= 1'b1;
		else
			case (rcv_mode)
				0:       pop <= 1'b1;
				1:       pop <= 1'($urandom_range(0, 1));
				2:       pop <= ($urandom_range(0, 7) == 0);
				default: pop <= 1'b0;
			endcase
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		dir_row_t    steer[$];
		int unsigned in_flight;
		// Seed the predictor with the reset state
		cfg_mss   = SEG_SIZE_RESET;
		cfg_wlim  = WIN_LIMIT_RESET;
		cfg_ithr  = INIT_THR_RESET;
		cc_stage  = PH_SLOW_START;
		cc_cwnd   = 32'(cfg_mss);
		cc_thresh = 32'(cfg_ithr) * 32'(cfg_mss);
		cc_dups   = '0;
		cc_base   = 0;
		cc_next   = 0;
		cc_timer  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle events, duplicates into recovery, then a full Reno cycle
		steer = {
			row_fixed(OP_NONE, 8'hFF, snapshot(1024, 1024, 6144, PH_SLOW_START,
				1'b0, 1'b0, 1'b0, 8'd0, 8'd0)),
			row_fixed(OP_EXPIRE, 8'h00, snapshot(1024, 1024, 6144, PH_SLOW_START,
				1'b0, 1'b0, 1'b0, 8'd0, 8'd0)),
			row_fixed(OP_ACK, 8'hFF, snapshot(1024, 1024, 6144, PH_SLOW_START,
				1'b0, 1'b0, 1'b0, 8'd0, 8'd0)),
			row_fixed(OP_ACK, 8'h00, snapshot(1024, 1024, 6144, PH_SLOW_START,
				1'b0, 1'b0, 1'b0, 8'd0, 8'd0)),
			row_fixed(OP_ACK, 8'h80, snapshot(3584, 3584, 3584, PH_RECOVERY,
				1'b1, 1'b0, 1'b0, 8'd0, 8'd0)),
			row_fixed(OP_ACK, 8'h7F, snapshot(4608, 4608, 3584, PH_RECOVERY,
				1'b0, 1'b0, 1'b0, 8'd0, 8'd0)),
			row_free(OP_SEND, 8'h55),
			row_free(OP_SEND, 8'hAA),
			row_free(OP_SEND, 8'h00),
			row_free(OP_SEND, 8'hFF),
			row_free(OP_SEND, 8'h3C),
			row_free(OP_ACK, 8'h01),
			row_free(OP_ACK, 8'h03),
			row_free(OP_ACK, 8'h03),
			row_free(OP_ACK, 8'h03),
			row_free(OP_ACK, 8'h03),
			row_free(OP_ACK, 8'hFE),
			row_free(OP_EXPIRE, 8'h00),
			row_free(OP_ACK, 8'h04),
			row_free(OP_EXPIRE, 8'h12),
			row_free(OP_NONE, 8'h33),
			row_free(OP_SEND, 8'hC3),
			row_free(OP_ACK, 8'h05)
		};
		foreach (steer[i])
			post_event(steer[i].ev, steer[i].typed, steer[i].want);
		run_traffic(200);

		// Smallest settings
		settle();
		program_regs(16'd1, 8'd1, 8'd1);
		run_traffic(200);

		// Largest settings, with a full sequence space
		settle();
		program_regs(16'hFFFF, 8'd255, 8'd255);
		run_traffic(150);
		flood_window();
		run_traffic(100);

		// Random settings and a long run of duplicates
		settle();
		program_regs(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)),
			8'($urandom_range(1, 255)));
		run_traffic(200);
		repeat (SEQ_SPACE + 4)
			offer(OP_ACK, 8'((cc_base + SEQ_SPACE - 1) % SEQ_SPACE));
		in_flight = (cc_next + SEQ_SPACE - cc_base) % SEQ_SPACE;
		if (in_flight != 0)
			offer(OP_ACK, 8'((cc_base + in_flight - 1) % SEQ_SPACE));

		settle();
		program_regs(16'd536, 8'd64, 8'd2);
		run_traffic(250);

		settle();
		program_regs(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)),
			8'($urandom_range(1, 255)));
		run_traffic(250);

		// Drain, then watch for stray beats
		push <= 1'b0;
		while (window_reports_due.size() != 0)
			@(posedge clk);
		tail_flush = 1'b1;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && window_reports_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/rcwc_pkg.sv
hw/rtl/rcwc_fifo.sv
hw/rtl/rcwc_front.sv
hw/rtl/rcwc_divider.sv
hw/rtl/rcwc_back.sv
hw/rtl/reno_congestion_window_control.sv
tb/sv/reno_congestion_window_control_test.sv
